FILE: src/lbsel_pkg.sv
// ----------------------------------------------------------------------------
// lbsel_pkg
// Shared types and codes for the backend load-balance selector: item layouts,
// register indexes, balance modes and the controller/datapath interface.
// ----------------------------------------------------------------------------
`default_nettype none

package lbsel_pkg;

   // Item commands
   localparam logic CMD_SELECT = 1'b0;
   localparam logic CMD_UPDATE = 1'b1;

   // Configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 5;
   localparam logic [CSR_IDX_W-1:0] CSR_BALANCE_MODE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ENTRY_COUNT  = 2'd1;

   // Balance modes; the remaining codes are unsupported
   localparam int MODE_W = 3;
   localparam logic [MODE_W-1:0] MODE_LOWEST_RTT  = 3'd0;
   localparam logic [MODE_W-1:0] MODE_MOST_IDLE   = 3'd1;
   localparam logic [MODE_W-1:0] MODE_ROUND_ROBIN = 3'd2;
   localparam logic [MODE_W-1:0] MODE_FIRST_IDLE  = 3'd3;

   localparam int COUNT_W        = 5;
   localparam int INDEX_W        = 4;
   localparam int IDLE_W         = 16;
   localparam int RTT_IN_W       = 32;
   localparam int RR_MIN_ENTRIES = 2;

   typedef struct packed {
      logic                cmd;
      logic [INDEX_W-1:0]  entry_index;
      logic [IDLE_W-1:0]   idle_value;
      logic [RTT_IN_W-1:0] rtt_value;
   } req_type;

   typedef struct packed {
      logic               found;
      logic [INDEX_W-1:0] chosen_index;
   } rsp_type;

   // Controller to datapath commands
   typedef struct packed {
      logic tbl_write;
      logic sel_start;
      logic scan_step;
      logic rsp_load;
   } dp_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic needs_scan;
      logic scan_last;
      logic rsp_free;
   } dp_status_type;

endpackage

`default_nettype wire

FILE: src/backend_load_balance_select_core.sv
// ----------------------------------------------------------------------------
// backend_load_balance_select_core
// Backend selector: keeps idle counts and round-trip times per backend and
// answers each select item with one backend index by the configured mode.
// ----------------------------------------------------------------------------
//  port group | direction | handshake            | content
//  req_*      | in        | req_valid/req_ready  | req_type: cmd, entry, idle, rtt
//  rsp_*      | out       | rsp_valid/rsp_ready  | rsp_type: found, chosen_index
//  csr_*      | in        | csr_we, no wait      | balance_mode, entry_count
//
//  An update writes the table directly. A select in lowest-rtt, most-idle or
//  first-idle mode scans n entries, n being the saturated entry count, the
//  scan reading one table entry per cycle; other selects skip the scan.
//  Synchronous reset clears the tables, round-robin state and registers,
//  bar best value and rsp data; req_ready rises the cycle after reset drops.
//  A result held in the output register stalls only the next select's emit
//  step; the scan itself runs on.
// ----------------------------------------------------------------------------
`default_nettype none

module backend_load_balance_select_core #(
   parameter int MAX_ENTRIES = 16,
   parameter int RTT_BITS    = 32
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  lbsel_pkg::req_type               req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output lbsel_pkg::rsp_type               rsp_data,
   input  logic                             csr_we,
   input  logic [lbsel_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [lbsel_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import lbsel_pkg::*;

   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;

   lbsel_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_cmd   (req_data.cmd),
      .req_ready (req_ready),
      .status    (dp_status),
      .cmd       (dp_cmd)
   );

   lbsel_dpath #(
      .MAX_ENTRIES (MAX_ENTRIES),
      .RTT_BITS    (RTT_BITS)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_data  (req_data),
      .cmd       (dp_cmd),
      .status    (dp_status),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

FILE: src/lbsel_ctrl.sv
// ----------------------------------------------------------------------------
// lbsel_ctrl
// Controller for the selector: accepts items, sequences the table scan and
// hands each selection result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module lbsel_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_cmd,
   output logic                   req_ready,
   input  lbsel_pkg::dp_status_type status,
   output lbsel_pkg::dp_cmd_type    cmd
);
   import lbsel_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_EMIT
   } state_type;

   state_type state_ff, state_in;
   logic      ready_ff;

   // Decide next state and datapath commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid && ready_ff) begin
               if (req_cmd == CMD_UPDATE) begin
                  cmd.tbl_write = 1'b1;
               end else begin
                  cmd.sel_start = 1'b1;
                  state_in      = status.needs_scan ? S_SCAN : S_EMIT;
               end
            end
         end
         S_SCAN: begin
            cmd.scan_step = 1'b1;
            if (status.scan_last) begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (status.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Hold state and the registered ready
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ready_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ready_ff <= (state_in == S_IDLE);
      end
   end

   assign req_ready = ready_ff;

endmodule

`default_nettype wire

FILE: src/lbsel_dpath.sv
// ----------------------------------------------------------------------------
// lbsel_dpath
// Datapath for the selector: configuration registers, backend tables,
// round-robin state, the scan unit and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module lbsel_dpath #(
   parameter int MAX_ENTRIES = 16,
   parameter int RTT_BITS    = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic [lbsel_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [lbsel_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  lbsel_pkg::req_type                   req_data,
   input  lbsel_pkg::dp_cmd_type                cmd,
   output lbsel_pkg::dp_status_type             status,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output lbsel_pkg::rsp_type                   rsp_data
);
   import lbsel_pkg::*;

   // Entries past min(MAX_ENTRIES, 16) cannot be written and read as zero
   localparam int TBL_DEPTH = (MAX_ENTRIES < 16) ? MAX_ENTRIES : 16;
   localparam int TBL_AW    = $clog2(TBL_DEPTH);
   // Largest count a selection can see after saturation
   localparam int SCAN_MAX  = (MAX_ENTRIES < 31) ? MAX_ENTRIES : 31;
   localparam int CNT_W     = $clog2(SCAN_MAX);
   localparam int N_W       = $clog2(SCAN_MAX + 1);
   localparam int VAL_W     = (RTT_BITS > IDLE_W) ? RTT_BITS : IDLE_W;

   logic [MODE_W-1:0]   mode_ff;
   logic [COUNT_W-1:0]  count_ff;
   logic [IDLE_W-1:0]   idle_tbl_ff [TBL_DEPTH];
   logic [RTT_BITS-1:0] rtt_tbl_ff  [TBL_DEPTH];
   logic [CNT_W-1:0]    rr_last_ff;
   logic                rr_has_ff;

   logic [MODE_W-1:0]   sel_mode_ff;
   logic [N_W-1:0]      n_ff;
   logic [CNT_W-1:0]    i_ff;
   logic [CNT_W-1:0]    res_idx_ff,   res_idx_in;
   logic                res_found_ff, res_found_in;
   logic [VAL_W-1:0]    best_val_ff,  best_val_in;
   logic                hit_ff,       hit_in;

   logic                rsp_valid_ff;
   logic                rsp_found_ff;
   logic [INDEX_W-1:0]  rsp_idx_ff;

   logic [N_W-1:0]      n_now;
   logic                wr_ok;
   logic [TBL_AW-1:0]   wr_addr;
   logic [RTT_BITS-1:0] wr_rtt_in;
   logic                rd_in_tbl;
   logic [IDLE_W-1:0]   rd_idle;
   logic [RTT_BITS-1:0] rd_rtt;
   logic [VAL_W-1:0]    rd_idle_ext;
   logic [VAL_W-1:0]    rd_rtt_ext;
   logic [N_W-1:0]      rr_cand;
   logic [CNT_W-1:0]    rr_pick;
   logic                rr_advance;
   logic                imm_found;
   logic [CNT_W-1:0]    imm_idx;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_LOWEST_RTT;
         count_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_BALANCE_MODE: mode_ff  <= csr_wdata[MODE_W-1:0];
            CSR_ENTRY_COUNT:  count_ff <= csr_wdata[COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   // Saturate the entry count to MAX_ENTRIES
   assign n_now = (32'(count_ff) > MAX_ENTRIES) ? N_W'(MAX_ENTRIES) : N_W'(count_ff);

   // Table write port
   assign wr_ok     = (32'(req_data.entry_index) < MAX_ENTRIES);
   assign wr_addr   = req_data.entry_index[TBL_AW-1:0];
   assign wr_rtt_in = RTT_BITS'(req_data.rtt_value);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < TBL_DEPTH; k++) begin
            idle_tbl_ff[k] <= '0;
            rtt_tbl_ff[k]  <= '0;
         end
      end else if (cmd.tbl_write && wr_ok) begin
         idle_tbl_ff[wr_addr] <= req_data.idle_value;
         rtt_tbl_ff[wr_addr]  <= wr_rtt_in;
      end
   end

   // Table read at the scan index; entries past the table read as zero
   assign rd_in_tbl   = (32'(i_ff) < TBL_DEPTH);
   assign rd_idle     = rd_in_tbl ? idle_tbl_ff[i_ff[TBL_AW-1:0]] : '0;
   assign rd_rtt      = rd_in_tbl ? rtt_tbl_ff[i_ff[TBL_AW-1:0]]  : '0;
   assign rd_idle_ext = VAL_W'(rd_idle);
   assign rd_rtt_ext  = VAL_W'(rd_rtt);

   // Round-robin candidate: next after the last pick, wrapping at the count
   always_comb begin
      rr_cand = rr_has_ff ? (N_W'(rr_last_ff) + N_W'(1)) : '0;
      if (rr_cand >= n_now) begin
         rr_cand = '0;
      end
      rr_pick = CNT_W'(rr_cand);
   end

   // Result known at the start: empty table, unsupported mode, round robin
   always_comb begin
      imm_found  = 1'b0;
      imm_idx    = '0;
      rr_advance = 1'b0;
      if (n_now != '0) begin
         case (mode_ff)
            MODE_LOWEST_RTT, MODE_MOST_IDLE, MODE_FIRST_IDLE: begin
               imm_found = 1'b1;
            end
            MODE_ROUND_ROBIN: begin
               imm_found = 1'b1;
               if (32'(n_now) >= RR_MIN_ENTRIES) begin
                  imm_idx    = rr_pick;
                  rr_advance = 1'b1;
               end
            end
            default: ;
         endcase
      end
   end

   // Round-robin state
   always_ff @(posedge clock) begin
      if (reset) begin
         rr_last_ff <= '0;
         rr_has_ff  <= 1'b0;
      end else if (cmd.sel_start && rr_advance) begin
         rr_last_ff <= rr_pick;
         rr_has_ff  <= 1'b1;
      end
   end

   // Start loads the immediate result; each scan step checks one entry vs best
   always_comb begin
      res_idx_in   = res_idx_ff;
      res_found_in = res_found_ff;
      best_val_in  = best_val_ff;
      hit_in       = hit_ff;
      if (cmd.sel_start) begin
         res_idx_in   = imm_idx;
         res_found_in = imm_found;
         hit_in       = 1'b0;
      end else if (cmd.scan_step) begin
         if (i_ff == '0) begin
            res_idx_in  = '0;
            best_val_in = (sel_mode_ff == MODE_LOWEST_RTT) ? rd_rtt_ext : rd_idle_ext;
            hit_in      = (rd_idle != '0);
         end else begin
            case (sel_mode_ff)
               MODE_LOWEST_RTT: begin
                  if (rd_rtt_ext < best_val_ff) begin
                     res_idx_in  = i_ff;
                     best_val_in = rd_rtt_ext;
                  end
               end
               MODE_MOST_IDLE: begin
                  if (rd_idle_ext > best_val_ff) begin
                     res_idx_in  = i_ff;
                     best_val_in = rd_idle_ext;
                  end
               end
               MODE_FIRST_IDLE: begin
                  if (!hit_ff && (rd_idle != '0)) begin
                     res_idx_in = i_ff;
                     hit_in     = 1'b1;
                  end
               end
               default: ;
            endcase
         end
      end
   end

   // Selection registers
   always_ff @(posedge clock) begin
      if (reset) begin
         i_ff         <= '0;
         n_ff         <= '0;
         sel_mode_ff  <= MODE_LOWEST_RTT;
         res_found_ff <= 1'b0;
         res_idx_ff   <= '0;
         hit_ff       <= 1'b0;
      end else begin
         if (cmd.sel_start) begin
            i_ff        <= '0;
            n_ff        <= n_now;
            sel_mode_ff <= mode_ff;
         end else if (cmd.scan_step) begin
            i_ff <= i_ff + CNT_W'(1);
         end
         res_found_ff <= res_found_in;
         res_idx_ff   <= res_idx_in;
         hit_ff       <= hit_in;
      end
   end

   always_ff @(posedge clock) begin
      best_val_ff <= best_val_in;
   end

   // Output register: load a result, drop it once taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_found_ff <= res_found_ff;
         rsp_idx_ff   <= res_found_ff ? INDEX_W'(res_idx_ff) : '0;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_data.found        = rsp_found_ff;
   assign rsp_data.chosen_index = rsp_idx_ff;

   // Status towards the controller
   always_comb begin
      status            = '0;
      status.needs_scan = (n_now != '0) &&
                          (mode_ff inside {MODE_LOWEST_RTT, MODE_MOST_IDLE, MODE_FIRST_IDLE});
      status.scan_last  = ((N_W'(i_ff) + N_W'(1)) == n_ff);
      status.rsp_free   = !rsp_valid_ff || rsp_ready;
   end

endmodule

`default_nettype wire

FILE: src/lbsel_check.sv
// ----------------------------------------------------------------------------
// lbsel_check
// Port-level checks for the backend selector, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module lbsel_check (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input lbsel_pkg::req_type req_data,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input lbsel_pkg::rsp_type rsp_data
);
   import lbsel_pkg::*;

   // Hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // No result out of reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // No backend means index zero
   a_not_found_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.found |-> rsp_data.chosen_index == '0)
      else $error("index set without a backend");

   // An accepted select leaves the block busy in the cycle after
   a_select_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_data.cmd == CMD_SELECT |=> !req_ready)
      else $error("ready while a select is in progress");

   // An update leaves the block ready in the next cycle
   a_update_single: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_data.cmd == CMD_UPDATE |=> req_ready)
      else $error("update did not complete in one cycle");

endmodule

bind backend_load_balance_select_core lbsel_check u_lbsel_check (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

`default_nettype wire
